@@ rtl/svl_pkg.sv @@
// Package for the scaled velocity limiter: state encoding, register indexes,
// mode codes, sequencer control struct and a saturation helper.
// Depends on nothing; used by scaled_velocity_limiter.
`timescale 1ns / 1ps

package svl_pkg;

	localparam int DATA_W    = 32;
	localparam int RATE_W    = 31;
	localparam int FRAC_W    = 16;
	localparam int DIV_STEPS = 48;
	localparam int ACC_W     = 66;
	localparam int PROD_W    = 50;
	localparam int ADDR_W    = 5;

	// Operating modes; codes six and seven behave as out of service.
	localparam logic [2:0] MODE_OS   = 3'd0;
	localparam logic [2:0] MODE_MAN  = 3'd1;
	localparam logic [2:0] MODE_AUT  = 3'd2;
	localparam logic [2:0] MODE_CAS  = 3'd3;
	localparam logic [2:0] MODE_RCAS = 3'd4;
	localparam logic [2:0] MODE_ROUT = 3'd5;

	// Register indexes (byte address divided by four).
	localparam logic [2:0] REG_SP_HIGH  = 3'd0;
	localparam logic [2:0] REG_SP_LOW   = 3'd1;
	localparam logic [2:0] REG_OUT_HIGH = 3'd2;
	localparam logic [2:0] REG_OUT_LOW  = 3'd3;
	localparam logic [2:0] REG_RATE_UP  = 3'd4;
	localparam logic [2:0] REG_RATE_DN  = 3'd5;
	localparam logic [2:0] REG_BYPASS   = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_SCALE,
		S_MAP,
		S_UP,
		S_DN,
		S_APPLY,
		S_RANGE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic scale_ld;
		logic mul_step;
		logic map_ld;
		logic up_ld;
		logic apply;
		logic range_upd;
		logic res_ld;
	} ctrl_t;

	// Saturates a sign-extended value to 32-bit two's complement.
	function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic all_one;
		logic any_one;
		all_one = &v[ACC_W-2:DATA_W-1];
		any_one = |v[ACC_W-2:DATA_W-1];
		if (v[ACC_W-1] && !all_one)
			return {1'b1, {(DATA_W-1){1'b0}}};
		else if (!v[ACC_W-1] && any_one)
			return {1'b0, {(DATA_W-1){1'b1}}};
		else
			return v[DATA_W-1:0];
	endfunction

endpackage

@@ rtl/scaled_velocity_limiter.sv @@
// Scaled velocity limiter top level: sequencer, divider, shared multiplier,
// configuration registers and result register.
// Depends on svl_pkg.
`timescale 1ns / 1ps

// One request on the input channel is one scan: a mode and candidate values.
// Each request gives exactly one result on the output channel, carrying the
// output, the setpoint, the applied change, the bad flag and four alarms.
// Both channels use valid and ready; configuration is to be written through the
// APB-style port only while the block is idle, which the block itself does not
// enforce, and every register reads back.
// Out of service, invalid mode and manual scans go from acceptance straight to
// the final step. Other scans run a restoring divider, one quotient bit per
// cycle, for the 48-bit range ratio quotient, then three products on a shared
// 33 x 17 bit multiplier, each built from three 16-bit slices of the ratio,
// then the limit and range steps (no range step in bypass). A new request is
// taken only once the sequencer has left its final step and is idle again.
//
// Reset loads the documented register defaults and clears output, setpoint,
// change and alarms. The result register frees the receiver side: while a
// result waits, the next request may be taken and worked on, and the sequencer
// only holds at its final step until the waiting result has been taken.
module scaled_velocity_limiter
	import svl_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               mode,
	input  logic signed [DATA_W-1:0] cascade_sp,
	input  logic signed [DATA_W-1:0] remote_sp,
	input  logic signed [DATA_W-1:0] remote_out,
	input  logic signed [DATA_W-1:0] manual_out,
	input  logic                     operator_sp_write,
	input  logic signed [DATA_W-1:0] operator_sp,

	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] out_value,
	output logic signed [DATA_W-1:0] sp_value,
	output logic signed [DATA_W-1:0] last_change,
	output logic                     bad_status,
	output logic                     alarm_rise,
	output logic                     alarm_fall,
	output logic                     alarm_low,
	output logic                     alarm_high,

	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	state_t state_q, state_d;
	ctrl_t  ctrl;

	// Configuration registers.
	logic signed [DATA_W-1:0] sp_hi_q, sp_lo_q, out_hi_q, out_lo_q;
	logic [RATE_W-1:0]        rate_up_q, rate_dn_q;
	logic                     bypass_q;

	// Block state.
	logic signed [DATA_W-1:0] out_reg_q, sp_reg_q, change_q;
	logic [3:0]               flags_q;
	logic                     bad_q;

	// Sequencer counters.
	logic [5:0] div_cnt_q;
	logic [1:0] mul_cnt_q;

	// Datapath registers.
	logic [DIV_STEPS-1:0]     dvd_q;
	logic [DATA_W-1:0]        rem_q;
	logic signed [DATA_W-1:0] scale_q;
	logic signed [DATA_W:0]   dif_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DATA_W-1:0] mapped_q;
	logic signed [PROD_W-1:0] up_q;

	// Result register.
	logic                     res_valid_q;
	logic signed [DATA_W-1:0] res_out_q, res_sp_q, res_change_q;
	logic                     res_bad_q;
	logic [3:0]               res_flags_q;

	logic cfg_wr;
	logic in_bad;
	logic done_free;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign in_ready = (state_q == S_IDLE);
	assign in_bad   = (mode == MODE_OS) || (mode > MODE_ROUT);
	assign done_free = !res_valid_q || out_ready;

	// ---------------------------------------------------------------- spans
	logic signed [DATA_W:0] num_w, den_w;
	logic [DATA_W-1:0]      num_mag, den_mag;
	logic                   den_zero;

	always_comb begin
		logic signed [DATA_W:0] num_neg;
		logic signed [DATA_W:0] den_neg;
		num_w    = {out_hi_q[DATA_W-1], out_hi_q} - {out_lo_q[DATA_W-1], out_lo_q};
		den_w    = {sp_hi_q[DATA_W-1], sp_hi_q} - {sp_lo_q[DATA_W-1], sp_lo_q};
		num_neg  = -num_w;
		den_neg  = -den_w;
		num_mag  = num_w[DATA_W] ? num_neg[DATA_W-1:0] : num_w[DATA_W-1:0];
		den_mag  = den_w[DATA_W] ? den_neg[DATA_W-1:0] : den_w[DATA_W-1:0];
		den_zero = (den_w == '0);
	end

	// -------------------------------------------------------------- divider
	logic [DATA_W:0]     rem_sh, rem_sub;
	logic [DATA_W-1:0]   rem_d;
	logic [DIV_STEPS-1:0] dvd_d;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[DIV_STEPS-1]};
		rem_sub = rem_sh - {1'b0, den_mag};
		if (!rem_sub[DATA_W]) begin
			rem_d = rem_sub[DATA_W-1:0];
			dvd_d = {dvd_q[DIV_STEPS-2:0], 1'b1};
		end else begin
			rem_d = rem_sh[DATA_W-1:0];
			dvd_d = {dvd_q[DIV_STEPS-2:0], 1'b0};
		end
	end

	// Signed, saturated Q16.16 ratio from the unsigned quotient.
	logic signed [DATA_W-1:0] scale_d;

	always_comb begin
		logic quo_neg;
		quo_neg = num_w[DATA_W] ^ den_w[DATA_W];
		if (den_zero) begin
			if (num_w == '0)
				scale_d = '0;
			else if (num_w[DATA_W])
				scale_d = {1'b1, {(DATA_W-1){1'b0}}};
			else
				scale_d = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (!quo_neg) begin
			if (|dvd_q[DIV_STEPS-1:DATA_W-1])
				scale_d = {1'b0, {(DATA_W-1){1'b1}}};
			else
				scale_d = dvd_q[DATA_W-1:0];
		end else begin
			if ((|dvd_q[DIV_STEPS-1:DATA_W]) ||
					(dvd_q[DATA_W-1] && (|dvd_q[DATA_W-2:0])))
				scale_d = {1'b1, {(DATA_W-1){1'b0}}};
			else
				scale_d = -dvd_q[DATA_W-1:0];
		end
	end

	// ----------------------------------------------------------- multiplier
	// The 33-bit operand times one 16-bit slice of the ratio per cycle, top
	// slice first, accumulated with a 16-bit shift.
	logic signed [DATA_W:0]   mul_a;
	logic signed [16:0]       mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc_d;
	logic [DIV_STEPS-1:0]     scale_ext;

	always_comb begin
		case (state_q)
			S_MAP:   mul_a = dif_q;
			S_UP:    mul_a = {2'b00, rate_up_q};
			default: mul_a = {2'b00, rate_dn_q};
		endcase
	end

	assign scale_ext = {{(DIV_STEPS-DATA_W){scale_q[DATA_W-1]}}, scale_q};

	always_comb begin
		case (mul_cnt_q)
			2'd0:    mul_b = {scale_ext[47], scale_ext[47:32]};
			2'd1:    mul_b = {1'b0, scale_ext[31:16]};
			default: mul_b = {1'b0, scale_ext[15:0]};
		endcase
	end

	assign prod = mul_a * mul_b;

	always_comb begin
		logic signed [ACC_W-1:0] acc_sh;
		acc_sh = (mul_cnt_q == 2'd0) ? '0 : {acc_q[ACC_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
		acc_d  = acc_sh + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
	end

	// Floor of the finished product divided by 2^16.
	logic signed [PROD_W-1:0] acc_fl;
	assign acc_fl = acc_q[ACC_W-1:FRAC_W];

	// -------------------------------------------------------- limiter steps
	logic [DATA_W-1:0]        mapped_d;
	logic signed [PROD_W-1:0] diff_w, neg_dn, change_w;
	logic                     rise, fall;
	logic signed [DATA_W-1:0] change_d, new_out;

	always_comb begin
		mapped_d = sat32({{(ACC_W-PROD_W){acc_fl[PROD_W-1]}}, acc_fl} +
			{{(ACC_W-DATA_W){out_lo_q[DATA_W-1]}}, out_lo_q});
		diff_w = {{(PROD_W-DATA_W){mapped_q[DATA_W-1]}}, mapped_q} -
			{{(PROD_W-DATA_W){out_reg_q[DATA_W-1]}}, out_reg_q};
		neg_dn = -acc_fl;
		rise   = diff_w > up_q;
		fall   = !rise && (diff_w < neg_dn);
		if (rise)
			change_w = up_q;
		else if (fall)
			change_w = neg_dn;
		else
			change_w = diff_w;
		change_d = sat32({{(ACC_W-PROD_W){change_w[PROD_W-1]}}, change_w});
		new_out  = sat32({{(ACC_W-DATA_W){out_reg_q[DATA_W-1]}}, out_reg_q} +
			{{(ACC_W-DATA_W){change_q[DATA_W-1]}}, change_q});
	end

	// ------------------------------------------------------------ sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_bad || mode == MODE_MAN)
						state_d = S_DONE;
					else
						state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (div_cnt_q == 6'(DIV_STEPS - 1))
					state_d = S_SCALE;
			end
			S_SCALE: state_d = S_MAP;
			S_MAP: begin
				if (mul_cnt_q == 2'd2)
					state_d = S_UP;
			end
			S_UP: begin
				if (mul_cnt_q == 2'd2)
					state_d = S_DN;
			end
			S_DN: begin
				if (mul_cnt_q == 2'd2)
					state_d = S_APPLY;
			end
			S_APPLY: state_d = bypass_q ? S_DONE : S_RANGE;
			S_RANGE: state_d = S_DONE;
			S_DONE: begin
				if (done_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			S_IDLE:  ctrl.accept = in_valid;
			S_DIV:   ctrl.div_step = 1'b1;
			S_SCALE: ctrl.scale_ld = 1'b1;
			S_MAP:   ctrl.mul_step = 1'b1;
			S_UP: begin
				ctrl.mul_step = 1'b1;
				ctrl.map_ld   = (mul_cnt_q == 2'd0);
			end
			S_DN: begin
				ctrl.mul_step = 1'b1;
				ctrl.up_ld    = (mul_cnt_q == 2'd0);
			end
			S_APPLY: ctrl.apply = 1'b1;
			S_RANGE: ctrl.range_upd = 1'b1;
			S_DONE:  ctrl.res_ld = done_free;
			default: ctrl = '0;
		endcase
	end

	// ------------------------------------------------ control state, reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_cnt_q   <= '0;
			mul_cnt_q   <= '0;
			res_valid_q <= 1'b0;
			sp_hi_q     <= 32'sd6553600;
			sp_lo_q     <= '0;
			out_hi_q    <= 32'sd6553600;
			out_lo_q    <= '0;
			rate_up_q   <= RATE_W'(65536);
			rate_dn_q   <= RATE_W'(65536);
			bypass_q    <= 1'b0;
			out_reg_q   <= '0;
			sp_reg_q    <= '0;
			change_q    <= '0;
			flags_q     <= '0;
			bad_q       <= 1'b0;
		end else begin
			state_q <= state_d;

			if (ctrl.accept)
				div_cnt_q <= '0;
			else if (ctrl.div_step)
				div_cnt_q <= div_cnt_q + 6'd1;

			if (ctrl.mul_step)
				mul_cnt_q <= (mul_cnt_q == 2'd2) ? 2'd0 : mul_cnt_q + 2'd1;
			else
				mul_cnt_q <= '0;

			if (ctrl.res_ld)
				res_valid_q <= 1'b1;
			else if (out_ready)
				res_valid_q <= 1'b0;

			if (cfg_wr) begin
				unique case (paddr[4:2])
					REG_SP_HIGH:  sp_hi_q   <= pwdata;
					REG_SP_LOW:   sp_lo_q   <= pwdata;
					REG_OUT_HIGH: out_hi_q  <= pwdata;
					REG_OUT_LOW:  out_lo_q  <= pwdata;
					REG_RATE_UP:  rate_up_q <= pwdata[RATE_W-1:0];
					REG_RATE_DN:  rate_dn_q <= pwdata[RATE_W-1:0];
					REG_BYPASS:   bypass_q  <= pwdata[0];
					default: ;
				endcase
			end

			if (ctrl.accept) begin
				bad_q <= in_bad;
				if (!in_bad) begin
					case (mode)
						MODE_CAS:  sp_reg_q <= cascade_sp;
						MODE_RCAS: sp_reg_q <= remote_sp;
						MODE_MAN, MODE_AUT: begin
							if (operator_sp_write)
								sp_reg_q <= operator_sp;
						end
						default: ;
					endcase
					if (mode == MODE_ROUT)
						out_reg_q <= remote_out;
					else if (mode == MODE_MAN)
						out_reg_q <= manual_out;
				end
			end

			if (ctrl.apply) begin
				if (bypass_q) begin
					out_reg_q <= mapped_q;
				end else begin
					change_q   <= change_d;
					flags_q[0] <= rise;
					// A rise limit leaves the fall alarm as it was.
					if (!rise)
						flags_q[1] <= fall;
				end
			end

			if (ctrl.range_upd) begin
				out_reg_q  <= new_out;
				flags_q[2] <= (new_out <= out_lo_q);
				flags_q[3] <= (new_out >= out_hi_q);
			end
		end
	end

	// ------------------------------------------------------- payload regs
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			dvd_q <= {num_mag, {FRAC_W{1'b0}}};
			rem_q <= '0;
		end else if (ctrl.div_step) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
		end

		if (ctrl.scale_ld) begin
			scale_q <= scale_d;
			dif_q   <= {sp_reg_q[DATA_W-1], sp_reg_q} - {sp_lo_q[DATA_W-1], sp_lo_q};
		end

		if (ctrl.mul_step)
			acc_q <= acc_d;
		if (ctrl.map_ld)
			mapped_q <= mapped_d;
		if (ctrl.up_ld)
			up_q <= acc_fl;

		if (ctrl.res_ld) begin
			res_out_q    <= out_reg_q;
			res_sp_q     <= sp_reg_q;
			res_change_q <= change_q;
			res_bad_q    <= bad_q;
			res_flags_q  <= flags_q;
		end
	end

	// ------------------------------------------------------------ read back
	always_comb begin
		unique case (paddr[4:2])
			REG_SP_HIGH:  prdata = sp_hi_q;
			REG_SP_LOW:   prdata = sp_lo_q;
			REG_OUT_HIGH: prdata = out_hi_q;
			REG_OUT_LOW:  prdata = out_lo_q;
			REG_RATE_UP:  prdata = {1'b0, rate_up_q};
			REG_RATE_DN:  prdata = {1'b0, rate_dn_q};
			REG_BYPASS:   prdata = {{(DATA_W-1){1'b0}}, bypass_q};
			default:      prdata = '0;
		endcase
	end

	assign out_valid   = res_valid_q;
	assign out_value   = res_out_q;
	assign sp_value    = res_sp_q;
	assign last_change = res_change_q;
	assign bad_status  = res_bad_q;
	assign alarm_rise  = res_flags_q[0];
	assign alarm_fall  = res_flags_q[1];
	assign alarm_low   = res_flags_q[2];
	assign alarm_high  = res_flags_q[3];

`ifndef NO_ASSERTIONS
	// An accepted request keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous scan still running");

	// A new result only ever comes from the final sequencer step.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result register loaded outside the final step");

	// The multiplier slice counter only runs through three slices.
	a_mul_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		mul_cnt_q != 2'd3)
		else $error("multiplier slice counter out of range");
`endif

endmodule
